// ===== design/hbsp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the H-bridge and servo PWM core: field widths, command codes,
// register indexes and the small conversion functions. Depends on nothing.

package hbsp_pkg;

  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int POWER_W    = 8;
  localparam int ANGLE_W    = 8;
  localparam int MPINS_W    = 8;
  localparam int SPINS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int MIDX_W     = 3;
  localparam int TRIM_W     = 6;
  localparam int SPEED_W    = 5;
  localparam int DIR_W      = 2;
  localparam int PULSE_W    = 5;
  // Wide enough for a trimmed and negated wheel power.
  localparam int WIDE_W     = 10;
  localparam int RECIP_W    = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_POWER = 2'd1,
    MODE_SERVO = 2'd2,
    MODE_WHEEL = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_INDEX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INDEX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_NEG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_NEG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM  = 3'd4;

  localparam logic [DIR_W-1:0] DIR_OFF = 2'b00;
  localparam logic [DIR_W-1:0] DIR_ONE = 2'b01;
  localparam logic [DIR_W-1:0] DIR_TWO = 2'b10;

  localparam logic signed [WIDE_W-1:0] POWER_LIMIT     = 10'sd20;
  localparam logic signed [WIDE_W-1:0] NEG_POWER_LIMIT = -10'sd20;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
  localparam logic [PULSE_W-1:0] PULSE_BASE = 5'd10;
  // Division by 18 as a multiply by 57/1024; exact for angles up to 180.
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 6'd57;
  localparam int                 RECIP_SHIFT = 10;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   dir;
  } motor_cmd_t;

  typedef struct packed {
    logic [MPINS_W-1:0] motor;
    logic [SPINS_W-1:0] servo;
  } pins_t;

  function automatic logic signed [WIDE_W-1:0] widen(input logic signed [POWER_W-1:0] p);
    return {{(WIDE_W-POWER_W){p[POWER_W-1]}}, p};
  endfunction

  // Saturate a power to +/-20 and split it into speed and direction.
  function automatic motor_cmd_t power_to_motor(input logic signed [WIDE_W-1:0] power);
    motor_cmd_t r;
    logic signed [WIDE_W-1:0] lim;
    logic signed [WIDE_W-1:0] mag;
    if (power > POWER_LIMIT) begin
      lim = POWER_LIMIT;
    end else if (power < NEG_POWER_LIMIT) begin
      lim = NEG_POWER_LIMIT;
    end else begin
      lim = power;
    end
    mag = (lim < 0) ? -lim : lim;
    r.speed = SPEED_W'(mag);
    if (lim > 0) begin
      r.dir = DIR_ONE;
    end else if (lim < 0) begin
      r.dir = DIR_TWO;
    end else begin
      r.dir = DIR_OFF;
    end
    return r;
  endfunction

  // Add the trim to the magnitude of a nonzero power without crossing zero.
  function automatic logic signed [WIDE_W-1:0] apply_trim(
    input logic signed [POWER_W-1:0] p,
    input logic signed [TRIM_W-1:0]  trim
  );
    logic signed [WIDE_W-1:0] pw;
    logic signed [WIDE_W-1:0] tw;
    logic signed [WIDE_W-1:0] s;
    pw = widen(p);
    tw = {{(WIDE_W-TRIM_W){trim[TRIM_W-1]}}, trim};
    s  = '0;
    if (pw > 0) begin
      s = pw + tw;
      if (s < 0) begin
        s = '0;
      end
    end else if (pw < 0) begin
      s = pw - tw;
      if (s > 0) begin
        s = '0;
      end
    end
    return s;
  endfunction

  // Pulse count for a nonzero angle: clamp to 180, then angle/18 + 10.
  function automatic logic [PULSE_W-1:0] angle_to_pulse(input logic [ANGLE_W-1:0] angle);
    logic [ANGLE_W-1:0]         a;
    logic [ANGLE_W+RECIP_W-1:0] prod;
    a    = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
    prod = (ANGLE_W+RECIP_W)'(a) * (ANGLE_W+RECIP_W)'(RECIP_MUL);
    return PULSE_W'(prod >> RECIP_SHIFT) + PULSE_BASE;
  endfunction

endpackage

// ===== design/hbsp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the H-bridge and servo PWM core:
// the command channel and the pin level channel. Depends on hbsp_pkg.

interface hbsp_cmd_if import hbsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [CHAN_W-1:0]         channel;
  logic signed [POWER_W-1:0] power_a;
  logic signed [POWER_W-1:0] power_b;
  logic [ANGLE_W-1:0]        angle;

  modport source (output valid, mode, channel, power_a, power_b, angle, input ready);
  modport sink   (input valid, mode, channel, power_a, power_b, angle, output ready);
endinterface

interface hbsp_pins_if import hbsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MPINS_W-1:0] motor_pins;
  logic [SPINS_W-1:0] servo_pins;

  modport source (output valid, motor_pins, servo_pins, input ready);
  modport sink   (input valid, motor_pins, servo_pins, output ready);
endinterface

// ===== design/hbridge_and_servo_pwm_core.sv =====
`timescale 1ns / 1ps
// Top level of the H-bridge and servo PWM core: four motor PWM channels and
// two RC servo channels. Depends on hbsp_pkg and the interfaces in hbsp_if.
//
//   Port     Direction  Beat carries
//   cmd      in         mode, channel, power_a, power_b, angle
//   levels   out        motor_pins, servo_pins (pin levels after the command)
//   cfg_*    in         register write: index and data, no read-back
//
// One command beat is taken per clock while cmd.ready is high; each beat gives
// one registered result beat. The work is a few compares and a small multiply
// between the state registers and the result register.
// A two-entry result buffer (output register plus skid register) lets a new
// command in while a result waits; cmd.ready drops only when both are full.
// Reset (rst, synchronous) clears counters, motor and servo settings, pin
// levels and the result buffer, and loads the register defaults.

module hbridge_and_servo_pwm_core import hbsp_pkg::*; #(
  parameter int MOTOR_STEPS = 20,
  parameter int SERVO_STEPS = 200,
  parameter int MOTOR_COUNT = 4,
  parameter int SERVO_COUNT = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hbsp_cmd_if.sink              cmd,
  hbsp_pins_if.source           levels
);

  localparam int MSTEP_W = $clog2(MOTOR_STEPS);
  localparam int SSTEP_W = $clog2(SERVO_STEPS);
  localparam int MCMP_W  = (MSTEP_W > SPEED_W) ? MSTEP_W : SPEED_W;
  localparam int SCMP_W  = (SSTEP_W > PULSE_W) ? SSTEP_W : PULSE_W;
  localparam logic [MSTEP_W-1:0] MSTEP_LAST = MSTEP_W'(MOTOR_STEPS - 1);
  localparam logic [SSTEP_W-1:0] SSTEP_LAST = SSTEP_W'(SERVO_STEPS - 1);

  // Configuration registers.
  logic [MIDX_W-1:0]        left_index;
  logic [MIDX_W-1:0]        right_index;
  logic                     left_neg;
  logic                     right_neg;
  logic signed [TRIM_W-1:0] right_trim;

  // PWM state.
  logic [MSTEP_W-1:0] motor_step, motor_step_next;
  logic [SSTEP_W-1:0] servo_step, servo_step_next;
  motor_cmd_t         motor_state      [MOTOR_COUNT];
  motor_cmd_t         motor_state_next [MOTOR_COUNT];
  logic [PULSE_W-1:0] servo_pulse      [SERVO_COUNT];
  logic [PULSE_W-1:0] servo_pulse_next [SERVO_COUNT];
  logic [MPINS_W-1:0] motor_pin_levels, motor_pin_levels_next;
  logic [SPINS_W-1:0] servo_pin_levels, servo_pin_levels_next;

  // Result buffer: out_* drives the port, skid_* holds a second result.
  logic  out_valid;
  pins_t out_data;
  logic  skid_valid;
  pins_t skid_data;

  logic  cmd_fire;
  logic  out_fire;
  mode_t cmd_mode;
  pins_t result;

  // Wheel sides after sign, and trim on the right, ready for the motor update.
  logic signed [WIDE_W-1:0] left_power;
  logic signed [WIDE_W-1:0] right_trimmed;
  logic signed [WIDE_W-1:0] right_power;
  motor_cmd_t               left_cmd;
  motor_cmd_t               right_cmd;
  motor_cmd_t               single_cmd;
  logic [PULSE_W-1:0]       new_pulse;

  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && !skid_valid;
  assign out_fire  = out_valid && levels.ready;
  assign cmd_mode  = mode_t'(cmd.mode);

  assign levels.valid      = out_valid;
  assign levels.motor_pins = out_data.motor;
  assign levels.servo_pins = out_data.servo;

  assign left_power    = left_neg ? -widen(cmd.power_a) : widen(cmd.power_a);
  assign right_trimmed = apply_trim(cmd.power_b, right_trim);
  assign right_power   = right_neg ? -right_trimmed : right_trimmed;
  assign left_cmd      = power_to_motor(left_power);
  assign right_cmd     = power_to_motor(right_power);
  assign single_cmd    = power_to_motor(widen(cmd.power_a));
  assign new_pulse     = angle_to_pulse(cmd.angle);

  // Next state for the accepted command. A tick evaluates the pins from the
  // current counters and settings and then advances both counters; commands
  // change settings only, apart from a servo turned off, whose pin drops.
  always_comb begin
    motor_step_next       = motor_step;
    servo_step_next       = servo_step;
    motor_pin_levels_next = motor_pin_levels;
    servo_pin_levels_next = servo_pin_levels;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      motor_state_next[k] = motor_state[k];
    end
    for (int k = 0; k < SERVO_COUNT; k++) begin
      servo_pulse_next[k] = servo_pulse[k];
    end
    if (cmd_fire) begin
      unique case (cmd_mode)
        MODE_TICK: begin
          motor_pin_levels_next = '0;
          for (int k = 0; k < MOTOR_COUNT; k++) begin
            if (MCMP_W'(motor_step) < MCMP_W'(motor_state[k].speed)) begin
              motor_pin_levels_next[2*k +: DIR_W] = motor_state[k].dir;
            end
          end
          // A servo that is off keeps whatever level its pin has.
          for (int k = 0; k < SERVO_COUNT; k++) begin
            if (servo_pulse[k] != '0) begin
              servo_pin_levels_next[k] = SCMP_W'(servo_step) < SCMP_W'(servo_pulse[k]);
            end
          end
          motor_step_next = (motor_step == MSTEP_LAST) ? '0 : motor_step + 1'b1;
          servo_step_next = (servo_step == SSTEP_LAST) ? '0 : servo_step + 1'b1;
        end
        MODE_POWER: begin
          for (int k = 0; k < MOTOR_COUNT; k++) begin
            if (cmd.channel == CHAN_W'(k + 1)) begin
              motor_state_next[k] = single_cmd;
            end
          end
        end
        MODE_SERVO: begin
          for (int k = 0; k < SERVO_COUNT; k++) begin
            if (cmd.channel == CHAN_W'(k + 1)) begin
              if (cmd.angle == '0) begin
                servo_pulse_next[k]      = '0;
                servo_pin_levels_next[k] = 1'b0;
              end else begin
                servo_pulse_next[k] = new_pulse;
              end
            end
          end
        end
        MODE_WHEEL: begin
          // The right side is checked first, so it wins on a shared motor.
          for (int k = 0; k < MOTOR_COUNT; k++) begin
            if (right_index == MIDX_W'(k + 1)) begin
              motor_state_next[k] = right_cmd;
            end else if (left_index == MIDX_W'(k + 1)) begin
              motor_state_next[k] = left_cmd;
            end
          end
        end
      endcase
    end
  end

  assign result.motor = motor_pin_levels_next;
  assign result.servo = servo_pin_levels_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_step       <= '0;
      servo_step       <= '0;
      motor_pin_levels <= '0;
      servo_pin_levels <= '0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        motor_state[k] <= '0;
      end
      for (int k = 0; k < SERVO_COUNT; k++) begin
        servo_pulse[k] <= '0;
      end
    end else begin
      motor_step       <= motor_step_next;
      servo_step       <= servo_step_next;
      motor_pin_levels <= motor_pin_levels_next;
      servo_pin_levels <= servo_pin_levels_next;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        motor_state[k] <= motor_state_next[k];
      end
      for (int k = 0; k < SERVO_COUNT; k++) begin
        servo_pulse[k] <= servo_pulse_next[k];
      end
    end
  end

  // Register writes. Indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_index  <= MIDX_W'(2);
      right_index <= MIDX_W'(3);
      left_neg    <= 1'b1;
      right_neg   <= 1'b0;
      right_trim  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_INDEX:  left_index  <= cfg_data[MIDX_W-1:0];
        REG_RIGHT_INDEX: right_index <= cfg_data[MIDX_W-1:0];
        REG_LEFT_NEG:    left_neg    <= cfg_data[0];
        REG_RIGHT_NEG:   right_neg   <= cfg_data[0];
        REG_RIGHT_TRIM:  right_trim  <= cfg_data[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Result buffer. A new command only arrives while the skid register is
  // empty; it goes to the output register when that one is free or being
  // emptied this cycle, otherwise into the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (cmd_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      if (!out_valid || out_fire) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

`ifndef SYNTHESIS
  // A full skid register always sits behind a full output register.
  assert property (@(posedge clk) disable iff (rst) !cmd.ready |-> levels.valid)
    else $error("skid register full while output register empty");

  // No motor ever drives both pins of its bridge at once.
  assert property (@(posedge clk) disable iff (rst)
    (motor_pin_levels & (motor_pin_levels >> 1) & 8'h55) == '0)
    else $error("motor bridge with both pins high");

  // Turning servo one off drops its pin right away.
  assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd_mode == MODE_SERVO && cmd.channel == CHAN_W'(1) && cmd.angle == '0
    |=> !servo_pin_levels[0])
    else $error("servo one pin high after turn-off");

  // The motor step counter stays inside its period.
  assert property (@(posedge clk) disable iff (rst) motor_step <= MSTEP_LAST)
    else $error("motor step counter out of range");
`endif

endmodule

// ===== test/pin_predictor_pkg.sv =====
`timescale 1ns / 1ps
// Command beat type and pin level predictor with its scoreboard for the
// H-bridge and servo PWM core testbench. Depends on hbsp_pkg.

package pin_predictor_pkg;
  import hbsp_pkg::*;

  localparam int MOTOR_PERIOD = 20;
  localparam int SERVO_PERIOD = 200;
  localparam int MOTOR_NUM    = 4;
  localparam int SERVO_NUM    = 2;
  localparam int SPEED_CAP    = 20;
  localparam int ANGLE_CAP    = 180;
  localparam int ANGLE_STEP   = 18;
  localparam int PULSE_OFFSET = 10;

  typedef struct {
    mode_t                     mode;
    logic [CHAN_W-1:0]         channel;
    logic signed [POWER_W-1:0] power_a;
    logic signed [POWER_W-1:0] power_b;
    logic [ANGLE_W-1:0]        angle;
  } cmd_beat_t;

  class pin_predictor;
    logic [SPEED_W-1:0]       motor_phase;
    logic [7:0]               servo_phase;
    logic [SPEED_W-1:0]       speed [MOTOR_NUM];
    logic [DIR_W-1:0]         dir [MOTOR_NUM];
    logic [PULSE_W-1:0]       pulse [SERVO_NUM];
    pins_t                    held;
    logic [MIDX_W-1:0]        left_index;
    logic [MIDX_W-1:0]        right_index;
    logic                     left_neg;
    logic                     right_neg;
    logic signed [TRIM_W-1:0] right_trim;
    pins_t                    expected_levels [$];
    int                       mismatches;
    int                       checked;
    int                       ticks;

    function new();
      motor_phase = '0;
      servo_phase = '0;
      foreach (speed[k]) begin
        speed[k] = '0;
        dir[k]   = DIR_OFF;
      end
      foreach (pulse[k]) pulse[k] = '0;
      held        = '0;
      left_index  = 3'd2;
      right_index = 3'd3;
      left_neg    = 1'b1;
      right_neg   = 1'b0;
      right_trim  = '0;
      mismatches  = 0;
      checked     = 0;
      ticks       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LEFT_INDEX:  left_index  = data[MIDX_W-1:0];
        REG_RIGHT_INDEX: right_index = data[MIDX_W-1:0];
        REG_LEFT_NEG:    left_neg    = data[0];
        REG_RIGHT_NEG:   right_neg   = data[0];
        REG_RIGHT_TRIM:  right_trim  = data[TRIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void set_power(int motor, int power);
      int p;
      if (motor < 1 || motor > MOTOR_NUM) return;
      p = (power > SPEED_CAP) ? SPEED_CAP : (power < -SPEED_CAP) ? -SPEED_CAP : power;
      speed[motor-1] = SPEED_W'(p < 0 ? -p : p);
      dir[motor-1]   = (p > 0) ? DIR_ONE : (p < 0) ? DIR_TWO : DIR_OFF;
    endfunction

    function void set_angle(int servo, int angle);
      int a;
      if (servo < 1 || servo > SERVO_NUM) return;
      if (angle == 0) begin
        // Turning a servo off pulls its pin low right away.
        pulse[servo-1]      = '0;
        held.servo[servo-1] = 1'b0;
        return;
      end
      a = (angle > ANGLE_CAP) ? ANGLE_CAP : angle;
      pulse[servo-1] = PULSE_W'(a / ANGLE_STEP + PULSE_OFFSET);
    endfunction

    function void advance();
      logic [MPINS_W-1:0] pins;
      pins = '0;
      for (int k = 0; k < MOTOR_NUM; k++) begin
        if (motor_phase < speed[k]) pins |= MPINS_W'(dir[k]) << (2 * k);
      end
      held.motor  = pins;
      motor_phase = (motor_phase == MOTOR_PERIOD - 1) ? '0 : motor_phase + 1'b1;
      // A servo that is off keeps whatever level its pin has.
      for (int k = 0; k < SERVO_NUM; k++) begin
        if (pulse[k] != 0) held.servo[k] = (servo_phase < pulse[k]);
      end
      servo_phase = (servo_phase == SERVO_PERIOD - 1) ? '0 : servo_phase + 1'b1;
    endfunction

    function void drive_wheels(int l, int r);
      int t;
      t = right_trim;
      if (r > 0) begin
        r = r + t;
        if (r < 0) r = 0;
      end else if (r < 0) begin
        r = r - t;
        if (r > 0) r = 0;
      end
      if (left_neg) l = -l;
      if (right_neg) r = -r;
      set_power(left_index, l);
      set_power(right_index, r);
    endfunction

    function void take_command(cmd_beat_t c);
      case (c.mode)
        MODE_TICK: begin
          advance();
          ticks++;
        end
        MODE_POWER: set_power(c.channel, c.power_a);
        MODE_SERVO: set_angle(c.channel, c.angle);
        default:    drive_wheels(c.power_a, c.power_b);
      endcase
      expected_levels.push_back(held);
    endfunction

    function void check_levels(logic [MPINS_W-1:0] motor, logic [SPINS_W-1:0] servo);
      pins_t want;
      if (expected_levels.size() == 0) begin
        $error("levels beat with no command pending: motor_pins %02h servo_pins %01h",
               motor, servo);
        mismatches++;
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (motor !== want.motor) begin
        $error("motor_pins: expected %02h, got %02h", want.motor, motor);
        mismatches++;
      end
      if (servo !== want.servo) begin
        $error("servo_pins: expected %01h, got %01h", want.servo, servo);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for hbridge_and_servo_pwm_core: clock, reset, command
// and register drivers, result sink and watchdog. Depends on hbsp_pkg,
// hbsp_if and pin_predictor_pkg.

module tb_top;
  import hbsp_pkg::*;
  import pin_predictor_pkg::*;

  // Cycles in a row with no beat on either channel before the run is abandoned.
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 150;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hbsp_cmd_if  cmd_ch ();
  hbsp_pins_if level_ch ();

  hbridge_and_servo_pwm_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .levels    (level_ch)
  );

  pin_predictor predictor;

  // When set, both sides run flat out with no gaps or stalls.
  bit steady_flow;
  int settings_used;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every input of the block holds a known value from time zero.
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.mode      <= '0;
    cmd_ch.channel   <= '0;
    cmd_ch.power_a   <= '0;
    cmd_ch.power_b   <= '0;
    cmd_ch.angle     <= '0;
    level_ch.ready   <= 1'b0;
  end

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic cmd_beat_t make_cmd(mode_t m, int ch, int pa, int pb, int ang);
    cmd_beat_t c;
    c.mode    = m;
    c.channel = CHAN_W'(ch);
    c.power_a = POWER_W'(pa);
    c.power_b = POWER_W'(pb);
    c.angle   = ANGLE_W'(ang);
    return c;
  endfunction

  // Powers mostly sit near the saturation window so that clamping and small
  // speeds both show up; the rest spans the full signed range.
  function automatic logic signed [POWER_W-1:0] draw_power();
    if ($urandom_range(0, 9) < 6) return POWER_W'($urandom_range(0, 50) - 25);
    return POWER_W'($urandom);
  endfunction

  function automatic cmd_beat_t random_cmd();
    cmd_beat_t c;
    int        kind;
    kind      = $urandom_range(0, 99);
    c.channel = CHAN_W'($urandom_range(0, 7));
    c.power_a = POWER_W'($urandom);
    c.power_b = POWER_W'($urandom);
    c.angle   = ANGLE_W'($urandom);
    if (kind < 50) begin
      c.mode = MODE_TICK;
    end else if (kind < 65) begin
      c.mode = MODE_POWER;
      if ($urandom_range(0, 99) < 85) c.channel = CHAN_W'($urandom_range(1, MOTOR_NUM));
      c.power_a = draw_power();
    end else if (kind < 80) begin
      c.mode = MODE_SERVO;
      if ($urandom_range(0, 99) < 85) c.channel = CHAN_W'($urandom_range(1, SERVO_NUM));
      case ($urandom_range(0, 9))
        0:       c.angle = '0;
        1:       c.angle = ANGLE_W'($urandom_range(ANGLE_CAP + 1, 255));
        default: c.angle = ANGLE_W'($urandom_range(1, ANGLE_CAP));
      endcase
    end else begin
      c.mode    = MODE_WHEEL;
      c.power_a = draw_power();
      c.power_b = draw_power();
    end
    return c;
  endfunction

  // Presents one command beat and returns at the edge where it is taken.
  // The valid line is left high, so a back-to-back beat just replaces the
  // payload; only a real gap lowers it.
  task automatic issue(cmd_beat_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.mode    <= c.mode;
    cmd_ch.channel <= c.channel;
    cmd_ch.power_a <= c.power_a;
    cmd_ch.power_b <= c.power_b;
    cmd_ch.angle   <= c.angle;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predictor.take_command(c);
  endtask

  // Must be called in the same step as the last accepted beat, before the
  // stale payload could be taken a second time.
  task automatic cmd_quiet();
    cmd_ch.valid <= 1'b0;
  endtask

  // Waits until every expected result has come back, then lets the block
  // settle.
  task automatic drain();
    while (predictor.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(int left_idx, int right_idx, bit lneg, bit rneg, int trim);
    logic [CFG_IDX_W-1:0]  idx  [5];
    logic [CFG_DATA_W-1:0] data [5];
    idx[0] = REG_LEFT_INDEX;  data[0] = CFG_DATA_W'(left_idx);
    idx[1] = REG_RIGHT_INDEX; data[1] = CFG_DATA_W'(right_idx);
    idx[2] = REG_LEFT_NEG;    data[2] = CFG_DATA_W'(lneg);
    idx[3] = REG_RIGHT_NEG;   data[3] = CFG_DATA_W'(rneg);
    idx[4] = REG_RIGHT_TRIM;  data[4] = CFG_DATA_W'(trim);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
      predictor.set_register(idx[i], data[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Motor index: usually a real motor, now and then 0 or past the last one,
  // which makes that wheel side a no-op.
  function automatic int draw_index();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, MOTOR_NUM);
    return $urandom_range(0, 7);
  endfunction

  // Result sink: draws a stall before each beat and checks every beat it takes.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        level_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      level_ch.ready <= 1'b1;
      @(posedge clk);
      while (!level_ch.valid) @(posedge clk);
      predictor.check_levels(level_ch.motor_pins, level_ch.servo_pins);
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (level_ch.valid && level_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    predictor     = new();
    steady_flow   = 1'b0;
    settings_used = 0;
    idle_cycles   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the reset register values (left wheel on motor
    // two negated, right wheel on motor three, no trim).
    // Saturation at both ends of the power range, zero power, and out-of-range
    // motor channels.
    issue(make_cmd(MODE_POWER, 1, 127, 0, 0));
    issue(make_cmd(MODE_POWER, 2, -128, 0, 0));
    issue(make_cmd(MODE_POWER, 3, 0, 0, 0));
    issue(make_cmd(MODE_POWER, 4, -20, 0, 0));
    issue(make_cmd(MODE_POWER, 0, 5, 0, 0));
    issue(make_cmd(MODE_POWER, 5, 7, 0, 0));
    // Angle above the clamp, the smallest angle, and a servo channel that
    // does not exist.
    issue(make_cmd(MODE_SERVO, 1, 0, 0, 255));
    issue(make_cmd(MODE_SERVO, 2, 0, 0, 1));
    issue(make_cmd(MODE_SERVO, 3, 0, 0, 90));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    issue(make_cmd(MODE_WHEEL, 0, 127, -128, 0));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    // Servo one is high here; turning it off must drop the pin at once,
    // without a tick.
    issue(make_cmd(MODE_SERVO, 1, 0, 0, 0));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    issue(make_cmd(MODE_POWER, 1, 21, 0, 0));
    issue(make_cmd(MODE_POWER, 2, -21, 0, 0));
    issue(make_cmd(MODE_SERVO, 2, 0, 0, 180));
    issue(make_cmd(MODE_SERVO, 1, 0, 0, 17));
    issue(make_cmd(MODE_SERVO, 1, 0, 0, 18));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    issue(make_cmd(MODE_WHEEL, 0, 0, 0, 0));
    issue(make_cmd(MODE_TICK, 0, 0, 0, 0));
    issue(make_cmd(MODE_POWER, 7, -1, 0, 0));
    // A tick ignores its other fields, so give them their extreme values.
    issue(make_cmd(MODE_TICK, 7, -128, 127, 255));
    cmd_quiet();

    // Random part: each phase starts from a fresh register setting, written
    // while the block is idle. The first phases hit the extremes: opposite
    // index ends with a negative and a positive trim, both wheels on
    // one motor (the right side must win), and index values that select no
    // motor at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       write_settings(1, MOTOR_NUM, 1'b0, 1'b0, -20);
        1:       write_settings(MOTOR_NUM, 1, 1'b1, 1'b1, 20);
        2:       write_settings(2, 2, 1'b0, 1'b1, 0);
        3:       write_settings(0, 7, 1'b1, 1'b0, 5);
        4:       write_settings(5, 6, 1'b0, 1'b0, -7);
        default: write_settings(draw_index(), draw_index(), 1'($urandom), 1'($urandom),
                                $urandom_range(0, 40) - 20);
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // Switch between bursts at full rate and stretches with random gaps.
        if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        issue(random_cmd());
      end
      cmd_quiet();
    end

    steady_flow = 1'b0;
    drain();
    $display("Checked %0d result beats (%0d of them ticks) across %0d register settings.",
             predictor.checked, predictor.ticks, settings_used);
    $display("Mismatches found: %0d", predictor.mismatches);
    if (predictor.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
